// ===== rtl/vn_pkg.sv =====
// shared types and constants for the vector normalize core
`timescale 1ns / 1ps

package vn_pkg;

  // number of vector components handled side by side
  localparam int LANES = 3;

  // per-stage control that rides along with the data
  typedef struct packed {
    logic valid;
    logic zero;
  } vn_ctrl_t;

endpackage

// ===== rtl/vn_div.sv =====
// pipelined restoring divider: one quotient bit per stage for all three lanes
`timescale 1ns / 1ps

module vn_div #(
  parameter int COMP_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  vn_pkg::vn_ctrl_t                  ctrl_i,
  input  logic [COMP_WIDTH-1:0]             abs_i  [vn_pkg::LANES],
  input  logic [vn_pkg::LANES-1:0]          neg_i,
  input  logic [COMP_WIDTH-1:0]             root_i,
  output vn_pkg::vn_ctrl_t                  ctrl_o,
  output logic [FRACTION_BITS:0]            quo_o  [vn_pkg::LANES],
  output logic [vn_pkg::LANES-1:0]          neg_o,
  output logic [COMP_WIDTH-1:0]             root_o
);
  import vn_pkg::*;

  localparam int STEPS = FRACTION_BITS + 1;
  localparam int QW    = FRACTION_BITS + 1;

  vn_ctrl_t                ctrl_r [STEPS+1];
  logic [COMP_WIDTH:0]     rem_r  [STEPS+1][LANES];
  logic [QW-1:0]           quo_r  [STEPS+1][LANES];
  logic [LANES-1:0]        neg_r  [STEPS+1];
  logic [COMP_WIDTH-1:0]   root_r [STEPS+1];

  // stage zero is the input itself
  always_comb begin
    ctrl_r[0] = ctrl_i;
    neg_r[0]  = neg_i;
    root_r[0] = root_i;
    for (int l = 0; l < LANES; l++) begin
      rem_r[0][l] = {1'b0, abs_i[l]};
      quo_r[0][l] = '0;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [COMP_WIDTH:0] rem_nxt [LANES];
    logic [QW-1:0]       quo_nxt [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic                ge;
      logic [COMP_WIDTH:0] diff;
      logic [QW:0]         qsh;
      assign ge   = rem_r[s][l] >= {1'b0, root_r[s]};
      assign diff = ge ? (rem_r[s][l] - {1'b0, root_r[s]}) : rem_r[s][l];
      // remainder stays below the divisor, so the shift cannot overflow
      assign rem_nxt[l] = {diff[COMP_WIDTH-1:0], 1'b0};
      assign qsh        = {quo_r[s][l], ge};
      assign quo_nxt[l] = qsh[QW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctrl_r[s+1].valid <= 1'b0;
      end else if (en) begin
        ctrl_r[s+1].valid <= ctrl_r[s].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctrl_r[s+1].zero <= ctrl_r[s].zero;
        neg_r[s+1]       <= neg_r[s];
        root_r[s+1]      <= root_r[s];
        for (int l = 0; l < LANES; l++) begin
          rem_r[s+1][l] <= rem_nxt[l];
          quo_r[s+1][l] <= quo_nxt[l];
        end
      end
    end
  end

  assign ctrl_o = ctrl_r[STEPS];
  assign neg_o  = neg_r[STEPS];
  assign root_o = root_r[STEPS];
  always_comb begin
    for (int l = 0; l < LANES; l++) quo_o[l] = quo_r[STEPS][l];
  end

endmodule

// ===== rtl/vector3_normalize_core.sv =====
// top level of the pipelined 3-vector normalize core
`timescale 1ns / 1ps

// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | comp_x, comp_y, comp_z (signed Q15.16)
// out_     | output    | out_valid/out_stall| unit_x/y/z (Q1.16), magnitude, zero_vector
//
// one transfer per cycle sustained while out_stall does not hold a result; the path runs
// through a square/sum front end, one root bit per stage, one quotient bit per stage, output reg
// the whole pipeline advances together; in_stall is high only while a result
// sits in the output register and out_stall holds it there
// reset is synchronous, active low, and clears only the valid bits

module vector3_normalize_core #(
  parameter int COMP_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COMP_WIDTH-1:0]  in_comp_x,
  input  logic signed [COMP_WIDTH-1:0]  in_comp_y,
  input  logic signed [COMP_WIDTH-1:0]  in_comp_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FRACTION_BITS+1:0] out_unit_x,
  output logic signed [FRACTION_BITS+1:0] out_unit_y,
  output logic signed [FRACTION_BITS+1:0] out_unit_z,
  output logic [COMP_WIDTH-1:0]         out_magnitude,
  output logic                          out_zero_vector
);
  import vn_pkg::*;

  localparam int LW = COMP_WIDTH / 2;        // low half of a magnitude
  localparam int HW = COMP_WIDTH - LW;       // high half
  localparam int SW = 2 * COMP_WIDTH;        // sum of squares
  localparam int RW = COMP_WIDTH + 2;        // root remainder
  localparam int QW = FRACTION_BITS + 1;     // quotient
  localparam int UW = FRACTION_BITS + 2;     // unit output
  localparam int NS = COMP_WIDTH;            // root stages

  // global advance: the output register is free or being emptied
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: absolute values and signs
  logic [COMP_WIDTH-1:0] comp [LANES];
  assign comp[0] = in_comp_x;
  assign comp[1] = in_comp_y;
  assign comp[2] = in_comp_z;

  vn_ctrl_t              s1_ctrl_r;
  logic [COMP_WIDTH-1:0] s1_abs_r [LANES];
  logic [LANES-1:0]      s1_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r.valid <= 1'b0;
    end else if (en) begin
      s1_ctrl_r.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctrl_r.zero <= (in_comp_x == '0) && (in_comp_y == '0) && (in_comp_z == '0);
      for (int l = 0; l < LANES; l++) begin
        s1_neg_r[l] <= comp[l][COMP_WIDTH-1];
        // most negative value maps to 2^(n-1), still fits unsigned
        s1_abs_r[l] <= comp[l][COMP_WIDTH-1] ? (~comp[l] + 1'b1) : comp[l];
      end
    end
  end

  // stage 2: partial products, each at most half width squared
  vn_ctrl_t              s2_ctrl_r;
  logic [COMP_WIDTH-1:0] s2_abs_r [LANES];
  logic [LANES-1:0]      s2_neg_r;
  logic [2*HW-1:0]       s2_hh_r  [LANES];
  logic [HW+LW-1:0]      s2_hl_r  [LANES];
  logic [2*LW-1:0]       s2_ll_r  [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctrl_r.valid <= 1'b0;
    end else if (en) begin
      s2_ctrl_r.valid <= s1_ctrl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctrl_r.zero <= s1_ctrl_r.zero;
      s2_neg_r       <= s1_neg_r;
      for (int l = 0; l < LANES; l++) begin
        s2_abs_r[l] <= s1_abs_r[l];
        s2_hh_r[l]  <= s1_abs_r[l][COMP_WIDTH-1:LW] * s1_abs_r[l][COMP_WIDTH-1:LW];
        s2_hl_r[l]  <= s1_abs_r[l][COMP_WIDTH-1:LW] * s1_abs_r[l][LW-1:0];
        s2_ll_r[l]  <= s1_abs_r[l][LW-1:0] * s1_abs_r[l][LW-1:0];
      end
    end
  end

  // stage 3: recombine each square
  vn_ctrl_t              s3_ctrl_r;
  logic [COMP_WIDTH-1:0] s3_abs_r [LANES];
  logic [LANES-1:0]      s3_neg_r;
  logic [SW-1:0]         s3_sq_r  [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctrl_r.valid <= 1'b0;
    end else if (en) begin
      s3_ctrl_r.valid <= s2_ctrl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctrl_r.zero <= s2_ctrl_r.zero;
      s3_neg_r       <= s2_neg_r;
      for (int l = 0; l < LANES; l++) begin
        s3_abs_r[l] <= s2_abs_r[l];
        s3_sq_r[l]  <= (SW'(s2_hh_r[l]) << (2 * LW))
                     + (SW'(s2_hl_r[l]) << (LW + 1))
                     + SW'(s2_ll_r[l]);
      end
    end
  end

  // square root pipeline; index 0 is the sum stage
  vn_ctrl_t              is_ctrl_r [NS+1];
  logic [SW-1:0]         is_sum_r  [NS+1];
  logic [RW-1:0]         is_rem_r  [NS+1];
  logic [COMP_WIDTH-1:0] is_root_r [NS+1];
  logic [COMP_WIDTH-1:0] is_abs_r  [NS+1][LANES];
  logic [LANES-1:0]      is_neg_r  [NS+1];

  // stage 4: sum of squares, below 2^SW even at full scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_ctrl_r[0].valid <= 1'b0;
    end else if (en) begin
      is_ctrl_r[0].valid <= s3_ctrl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_ctrl_r[0].zero <= s3_ctrl_r.zero;
      is_neg_r[0]       <= s3_neg_r;
      is_sum_r[0]       <= s3_sq_r[0] + s3_sq_r[1] + s3_sq_r[2];
      is_rem_r[0]       <= '0;
      is_root_r[0]      <= '0;
      for (int l = 0; l < LANES; l++) is_abs_r[0][l] <= s3_abs_r[l];
    end
  end

  // one root bit per stage, two radicand bits consumed from the top
  for (genvar k = 0; k < NS; k++) begin : g_root
    logic [1:0]          pair;
    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       trial;
    logic                ge;
    logic [COMP_WIDTH:0] root_sh;

    assign pair    = is_sum_r[k][SW-1-2*k -: 2];
    assign rem_sh  = {is_rem_r[k][RW-3:0], pair};
    assign trial   = {is_root_r[k], 2'b01};
    assign ge      = rem_sh >= trial;
    assign root_sh = {is_root_r[k], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        is_ctrl_r[k+1].valid <= 1'b0;
      end else if (en) begin
        is_ctrl_r[k+1].valid <= is_ctrl_r[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        is_ctrl_r[k+1].zero <= is_ctrl_r[k].zero;
        is_neg_r[k+1]       <= is_neg_r[k];
        is_sum_r[k+1]       <= is_sum_r[k];
        is_rem_r[k+1]       <= ge ? (rem_sh - trial) : rem_sh;
        is_root_r[k+1]      <= root_sh[COMP_WIDTH-1:0];
        for (int l = 0; l < LANES; l++) is_abs_r[k+1][l] <= is_abs_r[k][l];
      end
    end
  end

  // component / magnitude, one quotient bit per stage
  vn_ctrl_t              dv_ctrl;
  logic [QW-1:0]         dv_quo [LANES];
  logic [LANES-1:0]      dv_neg;
  logic [COMP_WIDTH-1:0] dv_root;

  vn_div #(
    .COMP_WIDTH    (COMP_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctrl_i (is_ctrl_r[NS]),
    .abs_i  (is_abs_r[NS]),
    .neg_i  (is_neg_r[NS]),
    .root_i (is_root_r[NS]),
    .ctrl_o (dv_ctrl),
    .quo_o  (dv_quo),
    .neg_o  (dv_neg),
    .root_o (dv_root)
  );

  // output register: clamp to one, apply sign, force zero vector result
  localparam logic [QW-1:0] UNIT_ONE = QW'(1) << FRACTION_BITS;

  logic [UW-1:0] unit_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [QW-1:0] q;
      q = (dv_quo[l] > UNIT_ONE) ? UNIT_ONE : dv_quo[l];
      if (dv_ctrl.zero) begin
        unit_nxt[l] = '0;
      end else if (dv_neg[l]) begin
        unit_nxt[l] = ~{1'b0, q} + 1'b1;
      end else begin
        unit_nxt[l] = {1'b0, q};
      end
    end
  end

  logic                  out_valid_r;
  logic [UW-1:0]         out_unit_r [LANES];
  logic [COMP_WIDTH-1:0] out_mag_r;
  logic                  out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_zero_r <= dv_ctrl.zero;
      out_mag_r  <= dv_ctrl.zero ? '0 : dv_root;
      for (int l = 0; l < LANES; l++) out_unit_r[l] <= unit_nxt[l];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = out_unit_r[0];
  assign out_unit_y      = out_unit_r[1];
  assign out_unit_z      = out_unit_r[2];
  assign out_magnitude   = out_mag_r;
  assign out_zero_vector = out_zero_r;

`ifndef SYNTHESIS
  // input held off only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // zero vector gives all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |->
      out_magnitude == '0 && out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0)
    else $error("zero vector with nonzero fields");

  // any nonzero vector has a nonzero length
  a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_vector |-> out_magnitude != '0)
    else $error("nonzero vector with zero magnitude");

  // a stalled result is not overwritten by the pipeline
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude) && $stable(out_unit_x))
    else $error("waiting result changed under stall");
`endif

endmodule
